### design/assert_macros.svh
// Assertion macros shared by the linked list unit's RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression holds at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed: invariant");

// The consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// The consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

### design/alfl_pkg.sv
// Types, codes and constants shared by the linked list unit.
`default_nettype none

package alfl_pkg;

    // Field widths.
    localparam int FUNC_W   = 2;
    localparam int VALUE_W  = 32;
    localparam int STAT_W   = 2;
    localparam int SLOT_W   = 4;

    // Default table depth.
    localparam int DEF_CAPACITY = 16;

    // Operation codes.
    localparam logic [FUNC_W-1:0] FUNC_APPEND = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_READ   = 2'd2;

    // Status codes.
    localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL      = 2'd1;
    localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 2'd2;
    localparam logic [STAT_W-1:0] STAT_EMPTY     = 2'd3;

    // Input item.
    typedef struct packed {
        logic [FUNC_W-1:0]         func;
        logic signed [VALUE_W-1:0] value;
    } t_in_item;

    // Result item.
    typedef struct packed {
        logic [STAT_W-1:0]         status;
        logic signed [VALUE_W-1:0] item_value;
        logic [SLOT_W-1:0]         slot;
        logic                      last;
    } t_out_item;

    // Source of a result's value and slot fields.
    typedef enum logic [1:0] {
        RES_NONE,   // handled value, slot zero
        RES_SLOT,   // handled value, current slot
        RES_MEM,    // stored value, current slot
        RES_ZERO    // zero value, slot zero
    } t_res_sel;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic              load;
        logic              seek_head;
        logic              seek_free;
        logic              seek_next;
        logic              app_link;
        logic              app_fin;
        logic              rm_unlink;
        logic              rm_free;
        logic              emit;
        logic              emit_last;
        logic [STAT_W-1:0] emit_status;
        t_res_sel          emit_sel;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic              head_null;
        logic              free_null;
        logic              match;
        logic              walk_end;
    } t_sts;

endpackage

`default_nettype wire

### design/array_linked_list_with_free_list_unit.sv
// Top level of the array-based linked list with free list.
//
//  channel   | handshake                  | payload
//  ----------+----------------------------+----------------------
//  command   | start / busy, taken when   | i_item   (t_in_item)
//            | start high and busy low    |
//  result    | o_result_strobe, one cycle | o_result (t_out_item)
//
// Append passes the dispatch, link and finish states before the next accept. Remove
// walks from the head to the first match (up to CAPACITY elements when none matches),
// unlinks it and frees its slot; read-out gives one result per element. The walk
// follows one link per cycle through the registered read port of the link table.
// Results show in the cycle after the controller emits them, so the last may show
// while the next item is taken. Reset is synchronous and needs no clearing pass:
// untouched slots chain by a fill count. The receiver cannot stall results.
`default_nettype none

module array_linked_list_with_free_list_unit
    import alfl_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     start,
    output logic          busy,
    input  wire t_in_item i_item,
    output logic          o_result_strobe,
    output t_out_item     o_result
);

    t_cmd cmd;
    t_sts sts;

    // Controller.
    alfl_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    // Datapath.
    alfl_dpath #(
        .CAPACITY (CAPACITY)
    ) u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_item          (i_item),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .o_result_strobe (o_result_strobe),
        .o_result        (o_result)
    );

endmodule

`default_nettype wire

### design/alfl_ctrl.sv
// Controller state machine of the linked list unit.
`default_nettype none

module alfl_ctrl
    import alfl_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic start,
    output logic      busy,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd
);

`include "assert_macros.svh"

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_DISPATCH = 3'd1;
    localparam logic [2:0] S_APP_LINK = 3'd2;
    localparam logic [2:0] S_APP_FIN  = 3'd3;
    localparam logic [2:0] S_RM_CMP   = 3'd4;
    localparam logic [2:0] S_RM_FREE  = 3'd5;
    localparam logic [2:0] S_RO_OUT   = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;

    assign busy = (r_state != S_IDLE);

    // Next state and command decode.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.emit_sel = RES_NONE;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                unique case (i_sts.func)
                    FUNC_APPEND: begin
                        if (i_sts.free_null) begin
                            o_cmd.emit        = 1'b1;
                            o_cmd.emit_last   = 1'b1;
                            o_cmd.emit_status = STAT_FULL;
                            o_cmd.emit_sel    = RES_NONE;
                            n_state           = S_IDLE;
                        end else begin
                            o_cmd.seek_free = 1'b1;
                            n_state         = S_APP_LINK;
                        end
                    end
                    FUNC_REMOVE: begin
                        if (i_sts.head_null) begin
                            o_cmd.emit        = 1'b1;
                            o_cmd.emit_last   = 1'b1;
                            o_cmd.emit_status = STAT_EMPTY;
                            o_cmd.emit_sel    = RES_NONE;
                            n_state           = S_IDLE;
                        end else begin
                            o_cmd.seek_head = 1'b1;
                            n_state         = S_RM_CMP;
                        end
                    end
                    FUNC_READ: begin
                        if (i_sts.head_null) begin
                            o_cmd.emit        = 1'b1;
                            o_cmd.emit_last   = 1'b1;
                            o_cmd.emit_status = STAT_EMPTY;
                            o_cmd.emit_sel    = RES_ZERO;
                            n_state           = S_IDLE;
                        end else begin
                            o_cmd.seek_head = 1'b1;
                            n_state         = S_RO_OUT;
                        end
                    end
                    default: begin
                        // The unused code is dropped without a result.
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_APP_LINK: begin
                o_cmd.app_link = 1'b1;
                n_state        = S_APP_FIN;
            end
            S_APP_FIN: begin
                o_cmd.app_fin     = 1'b1;
                o_cmd.emit        = 1'b1;
                o_cmd.emit_last   = 1'b1;
                o_cmd.emit_status = STAT_OK;
                o_cmd.emit_sel    = RES_SLOT;
                n_state           = S_IDLE;
            end
            S_RM_CMP: begin
                priority if (i_sts.match) begin
                    o_cmd.rm_unlink = 1'b1;
                    n_state         = S_RM_FREE;
                end else if (i_sts.walk_end) begin
                    o_cmd.emit        = 1'b1;
                    o_cmd.emit_last   = 1'b1;
                    o_cmd.emit_status = STAT_NOT_FOUND;
                    o_cmd.emit_sel    = RES_NONE;
                    n_state           = S_IDLE;
                end else begin
                    o_cmd.seek_next = 1'b1;
                end
            end
            S_RM_FREE: begin
                o_cmd.rm_free     = 1'b1;
                o_cmd.emit        = 1'b1;
                o_cmd.emit_last   = 1'b1;
                o_cmd.emit_status = STAT_OK;
                o_cmd.emit_sel    = RES_SLOT;
                n_state           = S_IDLE;
            end
            S_RO_OUT: begin
                // One element per cycle; the walk ends at a null link or after a full table.
                o_cmd.emit        = 1'b1;
                o_cmd.emit_last   = i_sts.walk_end;
                o_cmd.emit_status = STAT_OK;
                o_cmd.emit_sel    = RES_MEM;
                if (i_sts.walk_end) begin
                    n_state = S_IDLE;
                end else begin
                    o_cmd.seek_next = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // An accepted item keeps the unit busy in the next cycle.
    `ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy)
    // The final result of an item returns the controller to idle.
    `ASSERT_NEXT(a_last_idle, i_clk, i_rst_n, o_cmd.emit && o_cmd.emit_last, r_state == S_IDLE)

endmodule

`default_nettype wire

### design/alfl_dpath.sv
// Datapath of the linked list unit: slot tables, list pointers and result register.
`default_nettype none

module alfl_dpath
    import alfl_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_in_item i_item,
    input  wire t_cmd     i_cmd,
    output t_sts          o_sts,
    output logic          o_result_strobe,
    output t_out_item     o_result
);

`include "assert_macros.svh"

    localparam int IW = $clog2(CAPACITY);
    localparam int LW = $clog2(CAPACITY + 1);
    localparam logic [LW-1:0] NIL = LW'(CAPACITY);
    localparam logic [IW-1:0] LAST_STEP = IW'(CAPACITY - 1);

    // Slot tables.
    logic signed [VALUE_W-1:0] value_mem [CAPACITY];
    logic [LW-1:0]             link_mem  [CAPACITY];

    // Item and walk registers.
    logic [FUNC_W-1:0]         r_func;
    logic signed [VALUE_W-1:0] r_val;
    logic [LW-1:0]             r_cur;
    logic [LW-1:0]             r_prev;
    logic [IW-1:0]             r_cnt;
    logic signed [VALUE_W-1:0] r_rd_val;
    logic [LW-1:0]             r_rd_link;

    // List pointers; r_fill counts slots ever handed out, whose links are in the table.
    logic [LW-1:0] r_head;
    logic [LW-1:0] r_tail;
    logic [LW-1:0] r_free;
    logic [LW-1:0] r_fill;

    // Result register.
    logic      r_strobe;
    t_out_item r_res;
    t_out_item n_res;

    logic [LW-1:0] rd_addr;
    logic          link_we;
    logic [LW-1:0] link_wa;
    logic [LW-1:0] link_wd;
    logic          head_null;
    logic          tail_null;
    logic          prev_null;
    logic          fresh;

    assign head_null = (r_head >= NIL);
    assign tail_null = (r_tail >= NIL);
    assign prev_null = (r_prev >= NIL);
    assign fresh     = (r_cur == r_fill);

    assign o_sts.func      = r_func;
    assign o_sts.head_null = head_null;
    assign o_sts.free_null = (r_free >= NIL);
    assign o_sts.match     = (r_rd_val == r_val);
    assign o_sts.walk_end  = (r_cnt == LAST_STEP) || (r_rd_link >= NIL);

    // Read address: head, free head, or the link just read when following the chain.
    always_comb begin
        priority if (i_cmd.seek_head) begin
            rd_addr = r_head;
        end else if (i_cmd.seek_free) begin
            rd_addr = r_free;
        end else if (i_cmd.seek_next) begin
            rd_addr = r_rd_link;
        end else begin
            rd_addr = r_cur;
        end
    end

    // Link table write: one write per cycle.
    always_comb begin
        link_we = 1'b0;
        link_wa = r_cur;
        link_wd = NIL;
        priority if (i_cmd.app_link) begin
            link_we = !tail_null;
            link_wa = r_tail;
            link_wd = r_cur;
        end else if (i_cmd.app_fin) begin
            link_we = 1'b1;
            link_wa = r_cur;
            link_wd = NIL;
        end else if (i_cmd.rm_unlink) begin
            link_we = !prev_null;
            link_wa = r_prev;
            link_wd = r_rd_link;
        end else if (i_cmd.rm_free) begin
            link_we = 1'b1;
            link_wa = r_cur;
            link_wd = r_free;
        end else begin
            link_we = 1'b0;
        end
    end

    // Tables with registered reads.
    always_ff @(posedge i_clk) begin
        if (link_we) begin
            link_mem[link_wa[IW-1:0]] <= link_wd;
        end
        if (i_cmd.app_link) begin
            value_mem[r_cur[IW-1:0]] <= r_val;
        end
        r_rd_link <= link_mem[rd_addr[IW-1:0]];
        r_rd_val  <= value_mem[rd_addr[IW-1:0]];
    end

    // Item latch and walk position.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func <= i_item.func;
            r_val  <= i_item.value;
        end
        if (i_cmd.seek_head) begin
            r_cur  <= r_head;
            r_prev <= NIL;
            r_cnt  <= '0;
        end else if (i_cmd.seek_free) begin
            r_cur <= r_free;
        end else if (i_cmd.seek_next) begin
            r_prev <= r_cur;
            r_cur  <= r_rd_link;
            r_cnt  <= r_cnt + IW'(1);
        end
    end

    // List pointers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= NIL;
            r_tail <= NIL;
            r_free <= '0;
            r_fill <= '0;
        end else begin
            if (i_cmd.app_link) begin
                if (tail_null) begin
                    r_head <= r_cur;
                end
                r_tail <= r_cur;
                // A never-used slot links to the next one up, the last one to null.
                if (fresh) begin
                    r_free <= r_fill + LW'(1);
                    r_fill <= r_fill + LW'(1);
                end else begin
                    r_free <= r_rd_link;
                end
            end
            if (i_cmd.rm_unlink) begin
                if (prev_null) begin
                    r_head <= r_rd_link;
                end
                if (r_tail == r_cur) begin
                    r_tail <= r_prev;
                end
            end
            if (i_cmd.rm_free) begin
                r_free <= r_cur;
            end
        end
    end

    // Result fields.
    always_comb begin
        n_res.status = i_cmd.emit_status;
        n_res.last   = i_cmd.emit_last;
        unique case (i_cmd.emit_sel)
            RES_NONE: begin
                n_res.item_value = r_val;
                n_res.slot       = '0;
            end
            RES_SLOT: begin
                n_res.item_value = r_val;
                n_res.slot       = SLOT_W'(r_cur);
            end
            RES_MEM: begin
                n_res.item_value = r_rd_val;
                n_res.slot       = SLOT_W'(r_cur);
            end
            RES_ZERO: begin
                n_res.item_value = '0;
                n_res.slot       = '0;
            end
            default: begin
                n_res.item_value = r_val;
                n_res.slot       = '0;
            end
        endcase
    end

    // Result register: the strobe lasts one cycle per emitted item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_cmd.emit;
        end
        if (i_cmd.emit) begin
            r_res <= n_res;
        end
    end

    assign o_result_strobe = r_strobe;
    assign o_result        = r_res;

    // Head and tail are null together.
    `ASSERT_ALWAYS(a_head_tail, i_clk, i_rst_n, head_null == tail_null)
    // Link writes land on a real slot.
    `ASSERT_IMPL(a_link_wa, i_clk, i_rst_n, link_we, link_wa < NIL)
    // The count of used slots never passes the table depth.
    `ASSERT_ALWAYS(a_fill_range, i_clk, i_rst_n, r_fill <= NIL)

endmodule

`default_nettype wire

### tb/list_op_checker.sv
// Checker that predicts and compares the results of the linked list unit.
`timescale 1ns / 1ps

module list_op_checker
    import alfl_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_start,
    input  wire logic      i_busy,
    input  wire t_in_item  i_item,
    input  wire logic      i_result_strobe,
    input  wire t_out_item i_result,
    output int             o_fail_count,
    output int             o_results_due
);

    localparam int LINK_W = $clog2(CAPACITY + 1);
    localparam int IDX_W  = $clog2(CAPACITY);
    localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(CAPACITY);

    // Mirror of the table, the two chains and their ends.
    logic [VALUE_W-1:0] slot_values [CAPACITY];
    logic [LINK_W-1:0]  slot_links  [CAPACITY];
    logic [LINK_W-1:0]  list_first;
    logic [LINK_W-1:0]  list_last;
    logic [LINK_W-1:0]  free_first;

    // Results worked out for accepted items and not yet seen.
    t_out_item list_results_due [$];

    function automatic logic is_slot(input logic [LINK_W-1:0] p);
        return p < NULL_LINK;
    endfunction

    // Table index of a link that names a slot.
    function automatic logic [IDX_W-1:0] slot_idx(input logic [LINK_W-1:0] p);
        return p[IDX_W-1:0];
    endfunction

    function void queue_result(input logic [STAT_W-1:0] status,
                               input logic [VALUE_W-1:0] val,
                               input logic [LINK_W-1:0] slot,
                               input logic last);
        t_out_item r;
        r.status     = status;
        r.item_value = val;
        r.slot       = slot[SLOT_W-1:0];
        r.last       = last;
        list_results_due.push_back(r);
    endfunction

    // Back to the state after reset: the whole table on the free chain.
    function void clear_list();
        for (int i = 0; i < CAPACITY; i++) begin
            slot_values[i] = '0;
            slot_links[i]  = (i + 1 < CAPACITY) ? LINK_W'(i + 1) : NULL_LINK;
        end
        list_first = NULL_LINK;
        list_last  = NULL_LINK;
        free_first = '0;
        list_results_due.delete();
    endfunction

    // Apply one operation to the mirror and queue the results it gives.
    function void apply_list_op(input t_in_item op);
        logic [LINK_W-1:0] s;
        logic [LINK_W-1:0] prev;
        logic [LINK_W-1:0] nxt;
        logic              found;
        int                n;
        unique case (op.func)
            FUNC_APPEND: begin
                if (!is_slot(free_first)) begin
                    queue_result(STAT_FULL, op.value, '0, 1'b1);
                end else begin
                    s = free_first;
                    free_first = slot_links[slot_idx(s)];
                    slot_values[slot_idx(s)] = op.value;
                    slot_links[slot_idx(s)] = NULL_LINK;
                    if (is_slot(list_last)) begin
                        slot_links[slot_idx(list_last)] = s;
                    end else begin
                        list_first = s;
                    end
                    list_last = s;
                    queue_result(STAT_OK, op.value, s, 1'b1);
                end
            end
            FUNC_REMOVE: begin
                if (!is_slot(list_first)) begin
                    queue_result(STAT_EMPTY, op.value, '0, 1'b1);
                end else begin
                    // Walk from the head, keeping the predecessor of the match.
                    prev = NULL_LINK;
                    s = list_first;
                    found = 1'b0;
                    for (int steps = 0; steps < CAPACITY && is_slot(s) && !found;
                         steps++) begin
                        if (slot_values[slot_idx(s)] == op.value) begin
                            found = 1'b1;
                        end else begin
                            prev = s;
                            s = slot_links[slot_idx(s)];
                        end
                    end
                    if (!found) begin
                        queue_result(STAT_NOT_FOUND, op.value, '0, 1'b1);
                    end else begin
                        nxt = slot_links[slot_idx(s)];
                        if (is_slot(prev)) begin
                            slot_links[slot_idx(prev)] = nxt;
                        end else begin
                            list_first = nxt;
                        end
                        if (list_last == s) begin
                            list_last = prev;
                        end
                        slot_links[slot_idx(s)] = free_first;
                        free_first = s;
                        queue_result(STAT_OK, op.value, s, 1'b1);
                    end
                end
            end
            FUNC_READ: begin
                if (!is_slot(list_first)) begin
                    queue_result(STAT_EMPTY, '0, '0, 1'b1);
                end else begin
                    n = 0;
                    s = list_first;
                    while (n < CAPACITY && is_slot(s)) begin
                        nxt = slot_links[slot_idx(s)];
                        queue_result(STAT_OK, slot_values[slot_idx(s)], s,
                                     (n + 1 == CAPACITY) || !is_slot(nxt));
                        n++;
                        s = nxt;
                    end
                end
            end
            default: begin
                // The unused selector is ignored.
            end
        endcase
    endfunction

    // Field by field comparison against the oldest expected result.
    function void compare_result(input t_out_item want, input t_out_item got);
        if (got.status !== want.status) begin
            $error("status mismatch: expected %0d, got %0d", want.status, got.status);
            o_fail_count++;
        end
        if (got.item_value !== want.item_value) begin
            $error("item_value mismatch: expected %0d, got %0d",
                   want.item_value, got.item_value);
            o_fail_count++;
        end
        if (got.slot !== want.slot) begin
            $error("slot mismatch: expected %0d, got %0d", want.slot, got.slot);
            o_fail_count++;
        end
        if (got.last !== want.last) begin
            $error("last mismatch: expected %0d, got %0d", want.last, got.last);
            o_fail_count++;
        end
    endfunction

    // Results are checked before the item taken at the same edge is predicted.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_list();
            o_fail_count = 0;
        end else begin
            if (i_result_strobe) begin
                if (list_results_due.size() == 0) begin
                    $error("result with no item waiting: status %0d item_value %0d slot %0d",
                           i_result.status, i_result.item_value, i_result.slot);
                    o_fail_count++;
                end else begin
                    compare_result(list_results_due.pop_front(), i_result);
                end
            end
            if (i_start && !i_busy) begin
                apply_list_op(i_item);
            end
        end
        o_results_due <= list_results_due.size();
    end

endmodule

### tb/tb_array_linked_list_with_free_list_unit.sv
// Testbench top that drives list operations into the linked list unit.
`timescale 1ns / 1ps

module tb_array_linked_list_with_free_list_unit;
    import alfl_pkg::*;

    localparam int CAPACITY     = DEF_CAPACITY;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_ITEMS = 245;
    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

    logic      i_clk;
    logic      i_rst_n;
    logic      start;
    logic      busy;
    t_in_item  item;
    logic      result_strobe;
    t_out_item result;
    int        fail_count;
    int        results_due;
    int        cycle_count;
    logic      gaps_off;

    // Values currently on the list, oldest first, used to aim removes at hits.
    logic [VALUE_W-1:0] live_values [$];

    array_linked_list_with_free_list_unit #(
        .CAPACITY(CAPACITY)
    ) DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_item         (item),
        .o_result_strobe(result_strobe),
        .o_result       (result)
    );

    list_op_checker #(
        .CAPACITY(CAPACITY)
    ) u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_busy         (busy),
        .i_item         (item),
        .i_result_strobe(result_strobe),
        .i_result       (result),
        .o_fail_count   (fail_count),
        .o_results_due  (results_due)
    );

    // Free-running clock.
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Watchdog on the cycle count.
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    // Idle length before the next item: mostly none, sometimes a long one.
    function automatic int pick_gap();
        int k;
        k = $urandom_range(0, 99);
        if (gaps_off || k < 55) begin
            return 0;
        end else if (k < 85) begin
            return $urandom_range(1, 3);
        end else if (k < 96) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    // Present one item and hold it until the block takes it.
    task automatic send_item(input logic [FUNC_W-1:0] f, input logic [VALUE_W-1:0] v);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            start = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start      = 1'b1;
        item.func  = f;
        item.value = v;
        do begin
            @(posedge i_clk);
        end while (busy);
        @(negedge i_clk);
        // Keep the list of live values in step for choosing removes.
        if (f == FUNC_APPEND && live_values.size() < CAPACITY) begin
            live_values.push_back(v);
        end else if (f == FUNC_REMOVE) begin
            foreach (live_values[i]) begin
                if (live_values[i] == v) begin
                    live_values.delete(i);
                    break;
                end
            end
        end
    endtask

    // Hold off until every expected result has arrived.
    task automatic wait_drained();
        start = 1'b0;
        while (results_due != 0) @(negedge i_clk);
    endtask

    // Append operand: small values for duplicates, full range, and the extremes.
    function automatic logic [VALUE_W-1:0] pick_value();
        int k;
        k = $urandom_range(0, 9);
        if (k < 5) begin
            return $urandom_range(0, 7);
        end else if (k < 8) begin
            return $urandom;
        end else if (k == 8) begin
            return 32'h8000_0000;
        end
        return 32'h7FFF_FFFF;
    endfunction

    initial begin
        logic [VALUE_W-1:0] v;
        logic [VALUE_W-1:0] tail_value;
        int sent;
        int r;
        int grow;

        i_rst_n  = 1'b0;
        start    = 1'b0;
        item     = '0;
        gaps_off = 1'b0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part: empty cases, unused selector, fill to full, removes.
        send_item(FUNC_READ, 32'hDEAD_BEEF);
        send_item(FUNC_REMOVE, 32'd7);
        send_item(FUNC_UNUSED, 32'hFFFF_FFFF);
        send_item(FUNC_APPEND, 32'h8000_0000);
        send_item(FUNC_APPEND, 32'h7FFF_FFFF);
        send_item(FUNC_APPEND, 32'h0000_0000);
        send_item(FUNC_APPEND, 32'hFFFF_FFFF);
        send_item(FUNC_APPEND, 32'd5);
        send_item(FUNC_APPEND, 32'hAAAA_AAAA);
        send_item(FUNC_APPEND, 32'h5555_5555);
        send_item(FUNC_APPEND, 32'd1);
        send_item(FUNC_APPEND, 32'd5);
        for (int i = 0; i < CAPACITY - 9; i++) begin
            tail_value = $urandom;
            send_item(FUNC_APPEND, tail_value);
        end
        send_item(FUNC_APPEND, 32'hFFFF_FFFF);
        send_item(FUNC_READ, 32'h0);
        send_item(FUNC_REMOVE, 32'h1234_5678);
        send_item(FUNC_REMOVE, 32'd5);
        send_item(FUNC_REMOVE, 32'h8000_0000);
        send_item(FUNC_REMOVE, tail_value);
        send_item(FUNC_READ, 32'h0);

        wait_drained();

        // Random part: phases that grow and shrink the list in turn.
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            grow     = ((sent / 30) % 2) == 0;
            gaps_off = ((sent / 40) % 3) == 2;
            r = $urandom_range(0, 99);
            if (r < (grow ? 55 : 20)) begin
                send_item(FUNC_APPEND, pick_value());
                sent++;
            end else if (r < (grow ? 75 : 70)) begin
                if (live_values.size() > 0 && $urandom_range(0, 3) != 0) begin
                    v = live_values[$urandom_range(0, live_values.size() - 1)];
                end else if ($urandom_range(0, 1) == 0) begin
                    v = $urandom_range(0, 7);
                end else begin
                    v = $urandom;
                end
                send_item(FUNC_REMOVE, v);
                sent++;
            end else if (r < 95) begin
                send_item(FUNC_READ, $urandom);
                sent++;
            end else begin
                send_item(FUNC_UNUSED, $urandom);
            end
            if ($urandom_range(0, 49) == 0) begin
                wait_drained();
            end
        end

        // Let the last results come out, then give the verdict.
        wait_drained();
        repeat (CAPACITY + 8) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

### files.f
+incdir+design
design/alfl_pkg.sv
design/alfl_ctrl.sv
design/alfl_dpath.sv
design/array_linked_list_with_free_list_unit.sv
tb/list_op_checker.sv
tb/tb_array_linked_list_with_free_list_unit.sv
